// File: src/fwm_pkg.sv
// Shared constants, types and helpers for the fingerprint window matcher.
package fwm_pkg;

  localparam int WINDOW_WORDS = 32;
  localparam int WORD_BITS    = 32;

  localparam int IN_WORD_W = 32;
  localparam int SLOT_W    = 5;
  localparam int DIST_W    = 11;
  localparam int MISS_W    = 6;
  localparam int QLEN_W    = 16;
  localparam int POS_W     = 32;
  localparam int BIT_THR_W = 11;
  localparam int WRD_THR_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int PC_W   = $clog2(WORD_BITS + 1);
  localparam int FILL_W = $clog2(WINDOW_WORDS + 1);
  localparam int CNT_W  = $clog2(WINDOW_WORDS + 2);

  localparam logic [QLEN_W-1:0]    QUERY_LENGTH_RST   = 16'd32;
  localparam logic [QLEN_W-1:0]    QUERY_OFFSET_RST   = 16'd0;
  localparam logic [POS_W-1:0]     POSITION_COUNT_RST = 32'd0;
  localparam logic [WRD_THR_W-1:0] WORD_THRESHOLD_RST = 6'd10;
  localparam logic [BIT_THR_W-1:0] BIT_THRESHOLD_RST  = 11'd358;

  typedef enum logic [1:0] {
    ACT_QUERY = 2'd0,
    ACT_DB    = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_LENGTH   = 3'd0,
    REG_QUERY_OFFSET   = 3'd1,
    REG_POSITION_COUNT = 3'd2,
    REG_WORD_THRESHOLD = 3'd3,
    REG_BIT_THRESHOLD  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic                 shift;
    logic [WORD_BITS-1:0] q_word;
    logic [WRD_THR_W-1:0] word_threshold;
  } cell_ctl_t;

  typedef struct packed {
    logic [DIST_W-1:0] bit_sum;
    logic [MISS_W-1:0] miss;
  } sum_t;

  function automatic logic [PC_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + PC_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// File: src/fingerprint_window_match.sv
// Top level: config registers, search control and the row of compare cells.
//
//  channel | signals                                   | direction
//  item    | item_valid item_stall action slot word    | in (stall out)
//  result  | result_valid result_stall position...     | out (stall in)
//  config  | wr_en wr_index wr_data                    | in
//
// Query loads, clears and unscored database words do not start a scoring run.
// A scored database word stalls the item channel until its result is loaded: the sum ripples
// through the registered cell chain, one cell per cycle.
// A result waiting in the output register does not block the next item.
// Reset (rst, synchronous) clears control state; query words need loading.
module fingerprint_window_match (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    action,
  input  logic [fwm_pkg::SLOT_W-1:0]    query_slot,
  input  logic [fwm_pkg::IN_WORD_W-1:0] word,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [fwm_pkg::POS_W-1:0]     position,
  output logic [fwm_pkg::DIST_W-1:0]    bit_distance,
  output logic [fwm_pkg::MISS_W-1:0]    miss_words,
  output logic                          is_match,
  output logic [fwm_pkg::POS_W-1:0]     best_position,
  output logic [fwm_pkg::QLEN_W-1:0]    best_distance,
  input  logic                          wr_en,
  input  logic [fwm_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [fwm_pkg::CFG_DAT_W-1:0] wr_data
);

  localparam int W = fwm_pkg::WINDOW_WORDS;
  localparam logic [fwm_pkg::CNT_W-1:0]  LAST = fwm_pkg::CNT_W'(W + 1);
  localparam logic [fwm_pkg::FILL_W-1:0] FULL = fwm_pkg::FILL_W'(W);

  logic [fwm_pkg::QLEN_W-1:0]    query_length;
  logic [fwm_pkg::QLEN_W-1:0]    query_offset;
  logic [fwm_pkg::POS_W-1:0]     position_count;
  logic [fwm_pkg::WRD_THR_W-1:0] word_threshold;
  logic [fwm_pkg::BIT_THR_W-1:0] bit_threshold;

  fwm_pkg::state_t            state, state_next;
  logic [fwm_pkg::CNT_W-1:0]  cnt;
  logic [fwm_pkg::FILL_W-1:0] fill;
  logic [fwm_pkg::FILL_W-1:0] fill_next;
  logic [fwm_pkg::QLEN_W-1:0] skip;
  logic [fwm_pkg::POS_W-1:0]  pos_cnt;
  logic [fwm_pkg::POS_W-1:0]  best_pos_reg;
  logic [fwm_pkg::QLEN_W-1:0] best_dist_reg;

  logic accept, is_query, is_db, is_clear, full_now, do_skip, do_score;
  logic out_free, load, better;

  fwm_pkg::cell_ctl_t            ctl;
  logic [fwm_pkg::WORD_BITS-1:0] db_link [W+1];
  fwm_pkg::sum_t                 sum_link [W+1];

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      query_length   <= fwm_pkg::QUERY_LENGTH_RST;
      query_offset   <= fwm_pkg::QUERY_OFFSET_RST;
      position_count <= fwm_pkg::POSITION_COUNT_RST;
      word_threshold <= fwm_pkg::WORD_THRESHOLD_RST;
      bit_threshold  <= fwm_pkg::BIT_THRESHOLD_RST;
    end else if (wr_en) begin
      case (wr_index)
        fwm_pkg::REG_QUERY_LENGTH:   query_length   <= wr_data[fwm_pkg::QLEN_W-1:0];
        fwm_pkg::REG_QUERY_OFFSET:   query_offset   <= wr_data[fwm_pkg::QLEN_W-1:0];
        fwm_pkg::REG_POSITION_COUNT: position_count <= wr_data[fwm_pkg::POS_W-1:0];
        fwm_pkg::REG_WORD_THRESHOLD: word_threshold <= wr_data[fwm_pkg::WRD_THR_W-1:0];
        fwm_pkg::REG_BIT_THRESHOLD:  bit_threshold  <= wr_data[fwm_pkg::BIT_THR_W-1:0];
        default: ;
      endcase
    end
  end

  // item decode
  always_comb begin
    accept    = item_valid && !item_stall;
    is_query  = accept && (action == fwm_pkg::ACT_QUERY);
    is_db     = accept && (action == fwm_pkg::ACT_DB);
    is_clear  = accept && (action == fwm_pkg::ACT_CLEAR);
    fill_next = (fill == FULL) ? fill : fill + 1'b1;
    full_now  = (fill_next == FULL);
    do_skip   = full_now && (skip < query_offset);
    do_score  = is_db && full_now && !do_skip && (pos_cnt < position_count);
    out_free  = !result_valid || !result_stall;
    better    = {{(fwm_pkg::QLEN_W-fwm_pkg::MISS_W){1'b0}}, sum_link[W].miss}
                < best_dist_reg;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fwm_pkg::ST_IDLE: if (do_score) state_next = fwm_pkg::ST_RUN;
      fwm_pkg::ST_RUN: begin
        if (cnt == LAST) state_next = out_free ? fwm_pkg::ST_IDLE : fwm_pkg::ST_HOLD;
      end
      fwm_pkg::ST_HOLD: if (out_free) state_next = fwm_pkg::ST_IDLE;
      default: state_next = fwm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item_stall = 1'b1;
    load       = 1'b0;
    case (state)
      fwm_pkg::ST_IDLE: item_stall = 1'b0;
      fwm_pkg::ST_RUN:  load = (cnt == LAST) && out_free;
      fwm_pkg::ST_HOLD: load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwm_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state != fwm_pkg::ST_RUN) begin
        cnt <= '0;
      end else if (cnt != LAST) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // search counters and best tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      skip          <= '0;
      pos_cnt       <= '0;
      best_pos_reg  <= fwm_pkg::POSITION_COUNT_RST
                       + fwm_pkg::POS_W'(fwm_pkg::QUERY_LENGTH_RST);
      best_dist_reg <= fwm_pkg::QUERY_LENGTH_RST;
    end else if (is_clear) begin
      fill          <= '0;
      skip          <= '0;
      pos_cnt       <= '0;
      best_pos_reg  <= position_count + fwm_pkg::POS_W'(query_length);
      best_dist_reg <= query_length;
    end else begin
      if (is_db) begin
        fill <= fill_next;
        if (do_skip) skip <= skip + 1'b1;
      end
      if (load) begin
        pos_cnt <= pos_cnt + 1'b1;
        if (better) begin
          best_pos_reg  <= pos_cnt;
          best_dist_reg <= fwm_pkg::QLEN_W'(sum_link[W].miss);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      position      <= pos_cnt;
      bit_distance  <= sum_link[W].bit_sum;
      miss_words    <= sum_link[W].miss;
      is_match      <= sum_link[W].bit_sum < bit_threshold;
      best_position <= better ? pos_cnt : best_pos_reg;
      best_distance <= better ? fwm_pkg::QLEN_W'(sum_link[W].miss) : best_dist_reg;
    end
  end

  // cell row
  always_comb begin
    ctl.shift          = is_db;
    ctl.q_word         = word[fwm_pkg::WORD_BITS-1:0];
    ctl.word_threshold = word_threshold;
  end

  assign db_link[W]  = word[fwm_pkg::WORD_BITS-1:0];
  assign sum_link[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_cell
    fwm_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .q_we    (is_query && (int'(query_slot) == k)),
      .db_in   (db_link[k+1]),
      .db_out  (db_link[k]),
      .sum_in  (sum_link[k]),
      .sum_out (sum_link[k+1])
    );
  end

`ifndef SYNTHESIS
  a_run_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != fwm_pkg::ST_IDLE) |-> item_stall)
    else $error("item taken while scoring");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= LAST)
    else $error("ripple counter out of range");

  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (state == fwm_pkg::ST_HOLD) |-> result_valid)
    else $error("holding with empty output register");

  a_load_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == fwm_pkg::ST_RUN
                             || $past(state) == fwm_pkg::ST_HOLD))
    else $error("result appeared outside scoring");
`endif

endmodule

// File: src/fwm_cell.sv
// One compare cell: a database and a query word, bit count, running sums.
module fwm_cell (
  input  logic                          clk,
  input  fwm_pkg::cell_ctl_t            ctl,
  input  logic                          q_we,
  input  logic [fwm_pkg::WORD_BITS-1:0] db_in,
  output logic [fwm_pkg::WORD_BITS-1:0] db_out,
  input  fwm_pkg::sum_t                 sum_in,
  output fwm_pkg::sum_t                 sum_out
);

  logic [fwm_pkg::WORD_BITS-1:0] q;
  logic [fwm_pkg::PC_W-1:0]      pc;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      db_out <= db_in;
    end
    if (q_we) begin
      q <= ctl.q_word;
    end
    pc              <= fwm_pkg::popcount(q ^ db_out);
    sum_out.bit_sum <= sum_in.bit_sum + fwm_pkg::DIST_W'(pc);
    sum_out.miss    <= sum_in.miss + fwm_pkg::MISS_W'(pc > ctl.word_threshold);
  end

endmodule

// File: tb/sv/fwm_search_checker.sv
// Checker for the fingerprint window matcher: tracks the search and scores every result word.
module fwm_search_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  logic [1:0]                    action,
  input  logic [fwm_pkg::SLOT_W-1:0]    query_slot,
  input  logic [fwm_pkg::IN_WORD_W-1:0] word,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [fwm_pkg::POS_W-1:0]     position,
  input  logic [fwm_pkg::DIST_W-1:0]    bit_distance,
  input  logic [fwm_pkg::MISS_W-1:0]    miss_words,
  input  logic                          is_match,
  input  logic [fwm_pkg::POS_W-1:0]     best_position,
  input  logic [fwm_pkg::QLEN_W-1:0]    best_distance,
  input  logic                          wr_en,
  input  logic [fwm_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [fwm_pkg::CFG_DAT_W-1:0] wr_data,
  output int                            mismatches,
  output int                            due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [fwm_pkg::POS_W-1:0]  pos;
    logic [fwm_pkg::DIST_W-1:0] bit_sum;
    logic [fwm_pkg::MISS_W-1:0] miss;
    logic                       hit;
    logic [fwm_pkg::POS_W-1:0]  best_pos;
    logic [fwm_pkg::QLEN_W-1:0] best_miss;
  } score_t;

  logic [fwm_pkg::QLEN_W-1:0]    qlen_cfg, qoff_cfg;
  logic [fwm_pkg::POS_W-1:0]     pcount_cfg;
  logic [fwm_pkg::WRD_THR_W-1:0] wthr_cfg;
  logic [fwm_pkg::BIT_THR_W-1:0] bthr_cfg;

  logic [fwm_pkg::WORD_BITS-1:0] qwin [fwm_pkg::WINDOW_WORDS];
  logic [fwm_pkg::WORD_BITS-1:0] dbwin [fwm_pkg::WINDOW_WORDS];
  int unsigned                   fill, skipped;
  logic [fwm_pkg::POS_W-1:0]     scored, best_pos;
  logic [fwm_pkg::QLEN_W-1:0]    best_miss;
  score_t                        due_scores[$];
  int                            errs = 0;

  function automatic void restart_search();
    foreach (dbwin[k]) dbwin[k] = '0;
    fill = 0;
    skipped = 0;
    scored = '0;
    best_pos = pcount_cfg + fwm_pkg::POS_W'(qlen_cfg);
    best_miss = qlen_cfg;
  endfunction

  // shift one database word in; returns 1 when the new window is scored
  function automatic bit shift_and_score(input logic [fwm_pkg::WORD_BITS-1:0] w,
                                         output score_t s);
    int unsigned bit_total, miss, c;
    for (int k = 0; k < fwm_pkg::WINDOW_WORDS - 1; k++) dbwin[k] = dbwin[k + 1];
    dbwin[fwm_pkg::WINDOW_WORDS - 1] = w;
    if (fill < fwm_pkg::WINDOW_WORDS) fill++;
    if (fill < fwm_pkg::WINDOW_WORDS) return 1'b0;
    if (skipped < qoff_cfg) begin
      skipped++;
      return 1'b0;
    end
    if (scored >= pcount_cfg) return 1'b0;
    bit_total = 0;
    miss = 0;
    for (int k = 0; k < fwm_pkg::WINDOW_WORDS; k++) begin
      c = $countones(qwin[k] ^ dbwin[k]);
      bit_total += c;
      if (c > wthr_cfg) miss++;
    end
    s.pos = scored;
    if (miss < best_miss) begin
      best_miss = fwm_pkg::QLEN_W'(miss);
      best_pos = scored;
    end
    scored++;
    s.bit_sum = fwm_pkg::DIST_W'(bit_total);
    s.miss = fwm_pkg::MISS_W'(miss);
    s.hit = (bit_total < bthr_cfg);
    s.best_pos = best_pos;
    s.best_miss = best_miss;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      $display("%t %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    score_t want;
    if (rst) begin
      qlen_cfg = fwm_pkg::QUERY_LENGTH_RST;
      qoff_cfg = fwm_pkg::QUERY_OFFSET_RST;
      pcount_cfg = fwm_pkg::POSITION_COUNT_RST;
      wthr_cfg = fwm_pkg::WORD_THRESHOLD_RST;
      bthr_cfg = fwm_pkg::BIT_THRESHOLD_RST;
      foreach (qwin[k]) qwin[k] = '0;
      restart_search();
      due_scores.delete();
    end else begin
      if (wr_en) begin
        case (fwm_pkg::cfg_idx_t'(wr_index))
          fwm_pkg::REG_QUERY_LENGTH:   qlen_cfg = wr_data[fwm_pkg::QLEN_W-1:0];
          fwm_pkg::REG_QUERY_OFFSET:   qoff_cfg = wr_data[fwm_pkg::QLEN_W-1:0];
          fwm_pkg::REG_POSITION_COUNT: pcount_cfg = wr_data[fwm_pkg::POS_W-1:0];
          fwm_pkg::REG_WORD_THRESHOLD: wthr_cfg = wr_data[fwm_pkg::WRD_THR_W-1:0];
          fwm_pkg::REG_BIT_THRESHOLD:  bthr_cfg = wr_data[fwm_pkg::BIT_THR_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (due_scores.size() == 0) begin
          $display("%t result word at position %0d with none expected", $time, position);
          errs++;
        end else begin
          want = due_scores.pop_front();
          check_field("position", want.pos, position);
          check_field("bit_distance", want.bit_sum, bit_distance);
          check_field("miss_words", want.miss, miss_words);
          check_field("is_match", want.hit, is_match);
          check_field("best_position", want.best_pos, best_position);
          check_field("best_distance", want.best_miss, best_distance);
        end
      end
      if (item_valid && !item_stall) begin
        case (fwm_pkg::action_t'(action))
          fwm_pkg::ACT_QUERY: qwin[query_slot] = word[fwm_pkg::WORD_BITS-1:0];
          fwm_pkg::ACT_DB: begin
            if (shift_and_score(word[fwm_pkg::WORD_BITS-1:0], want))
              due_scores = {due_scores, want};
          end
          fwm_pkg::ACT_CLEAR: restart_search();
          default: ;
        endcase
      end
    end
    mismatches <= errs;
    due_count <= due_scores.size();
  end

endmodule

// File: tb/sv/tb_fingerprint_window_match.sv
// Testbench top for the fingerprint window matcher: stimulus, register setup and verdict.
module tb_fingerprint_window_match;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 1200;
  localparam int unsigned CALM_AFTER  = 1000;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned DRAIN_LIMIT = 5_000;
  localparam logic [fwm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [fwm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          item_valid = 1'b0;
  logic                          item_stall;
  logic [1:0]                    action = fwm_pkg::ACT_NONE;
  logic [fwm_pkg::SLOT_W-1:0]    query_slot = '0;
  logic [fwm_pkg::IN_WORD_W-1:0] word = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [fwm_pkg::POS_W-1:0]     position, best_position;
  logic [fwm_pkg::DIST_W-1:0]    bit_distance;
  logic [fwm_pkg::MISS_W-1:0]    miss_words;
  logic                          is_match;
  logic [fwm_pkg::QLEN_W-1:0]    best_distance;
  logic                          wr_en = 1'b0;
  logic [fwm_pkg::CFG_IDX_W-1:0] wr_index = '0;
  logic [fwm_pkg::CFG_DAT_W-1:0] wr_data = '0;

  int                            mismatches, due_count;
  int unsigned                   cycles = 0;
  int unsigned                   items_sent = 0;
  int unsigned                   align = 0;
  bit                            gaps_on = 1'b0;
  bit                            stall_on = 1'b0;
  logic [fwm_pkg::WORD_BITS-1:0] qimg [fwm_pkg::WINDOW_WORDS];

  fingerprint_window_match dut (.*);
  fwm_search_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_fingerprint_window_match: errors");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  function automatic logic [fwm_pkg::WORD_BITS-1:0] flip_mask(input int unsigned n);
    logic [fwm_pkg::WORD_BITS-1:0] m;
    m = '0;
    repeat (n) m[$urandom_range(0, fwm_pkg::WORD_BITS - 1)] = 1'b1;
    return m;
  endfunction

  task automatic send(input fwm_pkg::action_t a, input logic [fwm_pkg::SLOT_W-1:0] s,
                      input logic [fwm_pkg::IN_WORD_W-1:0] w);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= a;
    query_slot <= s;
    word <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic load_query(input logic [fwm_pkg::SLOT_W-1:0] s,
                            input logic [fwm_pkg::WORD_BITS-1:0] w);
    send(fwm_pkg::ACT_QUERY, s, w);
    qimg[s] = w;
  endtask

  task automatic write_reg(input logic [fwm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fwm_pkg::CFG_DAT_W-1:0] d);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= d;
    @(posedge clk);
  endtask

  // wait for every scored word, then idle on before returning
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (fwm_pkg::WINDOW_WORDS + 8) @(posedge clk);
  endtask

  task automatic configure(input logic [fwm_pkg::QLEN_W-1:0] qlen,
                           input logic [fwm_pkg::QLEN_W-1:0] qoff,
                           input logic [fwm_pkg::POS_W-1:0] pcount,
                           input logic [fwm_pkg::WRD_THR_W-1:0] wthr,
                           input logic [fwm_pkg::BIT_THR_W-1:0] bthr);
    settle();
    write_reg(fwm_pkg::REG_QUERY_LENGTH, {16'($urandom()), qlen});
    write_reg(fwm_pkg::REG_QUERY_OFFSET, {16'($urandom()), qoff});
    write_reg(fwm_pkg::REG_POSITION_COUNT, pcount);
    write_reg(fwm_pkg::REG_WORD_THRESHOLD, {26'($urandom()), wthr});
    write_reg(fwm_pkg::REG_BIT_THRESHOLD, {21'($urandom()), bthr});
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
    wr_en <= 1'b0;
    send(fwm_pkg::ACT_CLEAR, fwm_pkg::SLOT_W'($urandom()), $urandom());
    align = 0;
  endtask

  // mostly noisy copies of the query so aligned windows score low
  task automatic stream(input int unsigned n, input int unsigned noise);
    logic [fwm_pkg::WORD_BITS-1:0] w;
    logic [fwm_pkg::SLOT_W-1:0]    s;
    int unsigned                   r;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      s = fwm_pkg::SLOT_W'($urandom());
      if (r < 4) begin
        send(fwm_pkg::ACT_NONE, s, $urandom());
      end else if (r < 9) begin
        load_query(s, qimg[s] ^ flip_mask($urandom_range(0, 3)));
      end else if (r < 11) begin
        send(fwm_pkg::ACT_CLEAR, s, $urandom());
        align = 0;
      end else begin
        if ($urandom_range(0, 3) == 0)
          w = $urandom();
        else
          w = qimg[align % fwm_pkg::WINDOW_WORDS] ^ flip_mask($urandom_range(0, noise));
        send(fwm_pkg::ACT_DB, s, w);
        align++;
      end
      if (r >= 4) items_sent++;
    end
  endtask

  task automatic random_phase();
    logic [fwm_pkg::QLEN_W-1:0]    qlen, qoff;
    logic [fwm_pkg::POS_W-1:0]     pcount;
    logic [fwm_pkg::WRD_THR_W-1:0] wthr;
    logic [fwm_pkg::BIT_THR_W-1:0] bthr;
    case ($urandom_range(0, 9))
      0:       qlen = '0;
      1:       qlen = '1;
      2, 3, 4: qlen = fwm_pkg::QLEN_W'(fwm_pkg::WINDOW_WORDS);
      5:       qlen = fwm_pkg::QLEN_W'($urandom());
      default: qlen = fwm_pkg::QLEN_W'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 19))
      0:          qoff = '1;
      1, 2, 3, 4: qoff = fwm_pkg::QLEN_W'($urandom_range(1, 40));
      default:    qoff = '0;
    endcase
    case ($urandom_range(0, 9))
      0:       pcount = '0;
      1:       pcount = '1;
      2:       pcount = $urandom();
      default: pcount = $urandom_range(1, 60);
    endcase
    case ($urandom_range(0, 9))
      0:       wthr = '0;
      1:       wthr = '1;
      2:       wthr = fwm_pkg::WRD_THR_W'(fwm_pkg::WORD_BITS);
      3, 4:    wthr = fwm_pkg::WRD_THR_W'($urandom());
      default: wthr = fwm_pkg::WRD_THR_W'($urandom_range(4, 14));
    endcase
    case ($urandom_range(0, 9))
      0:       bthr = '0;
      1:       bthr = '1;
      2, 3:    bthr = fwm_pkg::BIT_THR_W'($urandom());
      default: bthr = fwm_pkg::BIT_THR_W'($urandom_range(60, 500));
    endcase
    gaps_on = items_sent < CALM_AFTER && $urandom_range(0, 3) != 0;
    stall_on = items_sent < CALM_AFTER && $urandom_range(0, 3) != 0;
    configure(qlen, qoff, pcount, wthr, bthr);
    items_sent++;
    stream($urandom_range(30, 110), $urandom_range(0, 16));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < fwm_pkg::WINDOW_WORDS; k++) begin
      if (k == 0)
        load_query(fwm_pkg::SLOT_W'(k), '0);
      else if (k == fwm_pkg::WINDOW_WORDS - 1)
        load_query(fwm_pkg::SLOT_W'(k), '1);
      else if (k == 1)
        load_query(fwm_pkg::SLOT_W'(k), 32'hAAAA_AAAA);
      else if (k == 2)
        load_query(fwm_pkg::SLOT_W'(k), 32'h5555_5555);
      else
        load_query(fwm_pkg::SLOT_W'(k), $urandom());
    end
    item_valid <= 1'b0;
    write_reg(REG_SPARE_HI, '1);
    wr_en <= 1'b0;

    // zero query length: best distance can never improve
    configure('0, '0, 32'd3, '0, '1);
    send(fwm_pkg::ACT_NONE, '1, '1);
    for (int k = 0; k < fwm_pkg::WINDOW_WORDS; k++)
      send(fwm_pkg::ACT_DB, fwm_pkg::SLOT_W'(k), qimg[k]);
    send(fwm_pkg::ACT_DB, '0, ~qimg[0]);
    send(fwm_pkg::ACT_DB, '1, '1);
    send(fwm_pkg::ACT_DB, '0, '0);

    // leading windows skipped, then full complement
    configure('1, 16'd2, 32'd2, '1, '0);
    send(fwm_pkg::ACT_DB, '0, $urandom());
    send(fwm_pkg::ACT_DB, '1, $urandom());
    for (int k = 0; k < fwm_pkg::WINDOW_WORDS; k++)
      send(fwm_pkg::ACT_DB, fwm_pkg::SLOT_W'(k), ~qimg[k]);
    send(fwm_pkg::ACT_DB, '0, $urandom());
    send(fwm_pkg::ACT_DB, '1, $urandom());

    while (items_sent < ITEM_TARGET) random_phase();

    item_valid <= 1'b0;
    @(posedge clk);
    for (int t = 0; t < DRAIN_LIMIT && due_count != 0; t++) @(posedge clk);
    repeat (fwm_pkg::WINDOW_WORDS + 8) @(posedge clk);
    if (due_count != 0)
      $display("%t %0d expected result words never arrived", $time, due_count);
    if (mismatches == 0 && due_count == 0) begin
      $display("tb_fingerprint_window_match: clean");
    end else begin
      $display("tb_fingerprint_window_match: errors");
    end
    $finish;
  end

endmodule
